// ----- src/tq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tq_pkg
// Shared types for the triple-ended queue: input and result words,
// operation codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package tq_pkg;

  typedef enum logic [2:0] {
    OP_ADD_HEAD = 3'd0,
    OP_ADD_TAIL = 3'd1,
    OP_ADD_MID  = 3'd2,
    OP_REM_HEAD = 3'd3,
    OP_REM_TAIL = 3'd4,
    OP_REM_MID  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       tap_sel;
  } cell_ctrl_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [8:0]         count;
  } out_word_t;

endpackage
`default_nettype wire

// ----- src/triple_ended_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// triple_ended_queue
// Bounded ordered store of signed words with add and remove at head, tail
// and middle, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// The queue shifts the cells from the target position onward in the cycle
// a command is accepted, so the stored contents and the count change at
// once. The removed word is read back through a registered OR tree over the
// cells, one level per cycle. Busy stays high from the accepting edge until
// the result strobe out_valid, which is high for one cycle; a new start can
// be taken in that strobe cycle, so a new command is taken only once the
// previous one is through. The receiver cannot stall; every command yields
// exactly one result word.
// ----------------------------------------------------------------------------
module triple_ended_queue #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire tq_pkg::in_word_t in_data,
  output logic                  busy,
  output logic                  out_valid,
  output tq_pkg::out_word_t     out_data
);
  import tq_pkg::*;

  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned LEVELS = $clog2(CAPACITY);
  localparam int unsigned LW     = $clog2(LEVELS + 1);

  logic [CW-1:0]   occ_r, occ_nxt;
  logic            busy_r;
  logic [LW-1:0]   lat_r;
  logic            out_valid_r;
  status_t         st_r, st_nxt;

  logic            accept;
  logic            full, empty;
  logic            do_add, do_rem;
  logic [CW-1:0]   pos;
  logic [CW-1:0]   occ_m1;

  cell_ctrl_t                  ctrl  [CAPACITY];
  logic [CAPACITY-1:0][31:0]   vals;
  logic [CAPACITY-1:0][31:0]   taps;
  logic [31:0]                 root;
  logic [CW+8:0]               count_ext;

  assign accept = start && !busy_r;
  assign full   = (occ_r == CW'(CAPACITY));
  assign empty  = (occ_r == '0);
  assign occ_m1 = occ_r - CW'(1);

  always_comb begin
    do_add = 1'b0;
    do_rem = 1'b0;
    pos    = '0;
    st_nxt = ST_OK;
    case (in_data.op)
      OP_ADD_HEAD: begin
        do_add = !full;
        pos    = '0;
        st_nxt = full ? ST_FULL : ST_OK;
      end
      OP_ADD_TAIL: begin
        do_add = !full;
        pos    = occ_r;
        st_nxt = full ? ST_FULL : ST_OK;
      end
      OP_ADD_MID: begin
        do_add = !full;
        pos    = occ_r >> 1;
        st_nxt = full ? ST_FULL : ST_OK;
      end
      OP_REM_HEAD: begin
        do_rem = !empty;
        pos    = '0;
        st_nxt = empty ? ST_EMPTY : ST_OK;
      end
      OP_REM_TAIL: begin
        do_rem = !empty;
        pos    = occ_m1;
        st_nxt = empty ? ST_EMPTY : ST_OK;
      end
      OP_REM_MID: begin
        do_rem = !empty;
        pos    = occ_m1 >> 1;
        st_nxt = empty ? ST_EMPTY : ST_OK;
      end
      default: begin
        do_add = 1'b0;
        do_rem = 1'b0;
        pos    = '0;
        st_nxt = ST_OK;
      end
    endcase
  end

  always_comb begin
    occ_nxt = occ_r;
    if (accept && do_add) begin
      occ_nxt = occ_r + CW'(1);
    end else if (accept && do_rem) begin
      occ_nxt = occ_m1;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic [31:0] left_v, right_v;

    always_comb begin
      ctrl[i].mode    = CELL_HOLD;
      ctrl[i].tap_sel = 1'b0;
      if (accept && do_add) begin
        if (IDX == pos) begin
          ctrl[i].mode = CELL_LOAD;
        end else if (IDX > pos) begin
          ctrl[i].mode = CELL_LEFT;
        end
      end else if (accept && do_rem) begin
        ctrl[i].tap_sel = (IDX == pos);
        if (IDX >= pos) begin
          ctrl[i].mode = CELL_RIGHT;
        end
      end
    end

    if (i == 0) begin : g_first
      assign left_v = 32'd0;
    end else begin : g_inner_l
      assign left_v = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = 32'd0;
    end else begin : g_inner_r
      assign right_v = vals[i+1];
    end

    tq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl[i]),
      .new_value   (in_data.value_in),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (vals[i]),
      .tap         (taps[i])
    );
  end

  tq_or_tree #(
    .LEAVES (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .taps (taps),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      busy_r      <= 1'b0;
      lat_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= 1'b0;
      if (accept) begin
        busy_r <= 1'b1;
        lat_r  <= LW'(LEVELS);
      end else if (busy_r) begin
        lat_r <= lat_r - LW'(1);
        if (lat_r == LW'(1)) begin
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r <= st_nxt;
    end
  end

  assign count_ext = {{9{1'b0}}, occ_r};

  assign busy               = busy_r;
  assign out_valid          = out_valid_r;
  assign out_data.value_out = root;
  assign out_data.status    = st_r;
  assign out_data.count     = count_ext[8:0];

endmodule
`default_nettype wire

// ----- src/tq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tq_cell
// One queue entry: holds, loads a new value, or takes its left or right
// neighbor; drives its value onto the read tap when selected.
// ----------------------------------------------------------------------------
module tq_cell (
  input  wire logic              clk,
  input  wire tq_pkg::cell_ctrl_t ctrl,
  input  wire logic [31:0]       new_value,
  input  wire logic [31:0]       left_value,
  input  wire logic [31:0]       right_value,
  output logic [31:0]            value,
  output logic [31:0]            tap
);
  import tq_pkg::*;

  logic [31:0] value_r;
  logic [31:0] value_nxt;

  always_comb begin
    case (ctrl.mode)
      CELL_LOAD:  value_nxt = new_value;
      CELL_LEFT:  value_nxt = left_value;
      CELL_RIGHT: value_nxt = right_value;
      default:    value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign tap   = ctrl.tap_sel ? value_r : 32'd0;

endmodule
`default_nettype wire

// ----- src/tq_or_tree.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tq_or_tree
// Registered OR reduction over the cell taps, one tree level per cycle.
// ----------------------------------------------------------------------------
module tq_or_tree #(
  parameter int unsigned LEAVES = 256
) (
  input  wire logic                     clk,
  input  wire logic [LEAVES-1:0][31:0]  taps,
  output logic [31:0]                   root
);
  localparam int unsigned LEVELS = (LEAVES < 2) ? 1 : $clog2(LEAVES);
  localparam int unsigned P      = 1 << LEVELS;
  localparam int unsigned NODES  = 2 * P - 1;

  logic [31:0] node_r [NODES];

  always_ff @(posedge clk) begin
    for (int k = 0; k < P - 1; k++) begin
      node_r[k] <= node_r[2*k+1] | node_r[2*k+2];
    end
    for (int j = 0; j < P; j++) begin
      if (j < LEAVES) begin
        node_r[P-1+j] <= taps[j];
      end else begin
        node_r[P-1+j] <= 32'd0;
      end
    end
  end

  assign root = node_r[0];

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triple-ended queue. A short table of directed
// words covers the empty and extreme cases and every operation code. Random
// phases then follow, in turn biased to fill, to drain and to mix, so the
// queue runs into its full and empty limits. Each accepted word is
// run through a model of the queue, and each strobed result is compared field
// by field with the oldest expected word.
// ----------------------------------------------------------------------------
module testbench;
  import tq_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam int LATENCY = $clog2(DEPTH);
  localparam int RANDOM_ITEMS = 1330;
  localparam int STALL_LIMIT = 4000;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    logic [2:0]  code;
    logic [31:0] val;
    logic        typed;
    out_word_t   want;
  } row_t;

  localparam row_t DIRECTED [21] = '{
    '{OP_REM_HEAD, 32'h0000_0000, 1'b1, '{32'sd0, ST_EMPTY, 9'd0}},
    '{OP_REM_TAIL, 32'hFFFF_FFFF, 1'b1, '{32'sd0, ST_EMPTY, 9'd0}},
    '{OP_REM_MID,  32'h8000_0000, 1'b1, '{32'sd0, ST_EMPTY, 9'd0}},
    '{OP_SPARE_A,  32'hFFFF_FFFF, 1'b1, '{32'sd0, ST_OK, 9'd0}},
    '{OP_ADD_HEAD, 32'h7FFF_FFFF, 1'b1, '{32'sd0, ST_OK, 9'd1}},
    '{OP_ADD_TAIL, 32'h8000_0000, 1'b1, '{32'sd0, ST_OK, 9'd2}},
    '{OP_ADD_MID,  32'h0000_0000, 1'b1, '{32'sd0, ST_OK, 9'd3}},
    '{OP_ADD_MID,  32'hFFFF_FFFF, 1'b0, '0},
    '{OP_ADD_HEAD, 32'h5555_5555, 1'b0, '0},
    '{OP_ADD_TAIL, 32'hAAAA_AAAA, 1'b0, '0},
    '{OP_SPARE_B,  32'h1234_5678, 1'b0, '0},
    '{OP_REM_MID,  32'hDEAD_BEEF, 1'b0, '0},
    '{OP_REM_HEAD, 32'h0000_0000, 1'b0, '0},
    '{OP_REM_TAIL, 32'h0000_0000, 1'b0, '0},
    '{OP_REM_MID,  32'h0000_0000, 1'b0, '0},
    '{OP_REM_MID,  32'h0000_0000, 1'b0, '0},
    '{OP_REM_TAIL, 32'h0000_0000, 1'b0, '0},
    '{OP_REM_HEAD, 32'hDEAD_BEEF, 1'b1, '{32'sd0, ST_EMPTY, 9'd0}},
    '{OP_ADD_MID,  32'h0000_0001, 1'b0, '0},
    '{OP_REM_MID,  32'h0000_0000, 1'b0, '0},
    '{OP_SPARE_A,  32'h0000_0000, 1'b1, '{32'sd0, ST_OK, 9'd0}}
  };

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_data;

  logic signed [31:0] slots[$];
  out_word_t          due_words[$];
  int                 mismatches = 0;
  int                 sent = 0;
  int                 stall_cycles = 0;

  triple_ended_queue #(.CAPACITY(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_word_t queue_op_result(input logic [2:0] code,
                                                input logic signed [31:0] val);
    out_word_t r;
    int n;
    r = '0;
    n = slots.size();
    case (code)
      OP_ADD_HEAD, OP_ADD_TAIL, OP_ADD_MID: begin
        if (n >= DEPTH) r.status = ST_FULL;
        else if (code == OP_ADD_HEAD) slots.push_front(val);
        else if (code == OP_ADD_TAIL) slots.push_back(val);
        else slots.insert(n / 2, val);
      end
      OP_REM_HEAD, OP_REM_TAIL, OP_REM_MID: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (code == OP_REM_HEAD) begin
          r.value_out = slots.pop_front();
        end else if (code == OP_REM_TAIL) begin
          r.value_out = slots.pop_back();
        end else begin
          r.value_out = slots[(n - 1) / 2];
          slots.delete((n - 1) / 2);
        end
      end
      default: ;
    endcase
    r.count = 9'(slots.size());
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [2:0] pick_op(input int add_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
    if (roll < add_pct) begin
      case ($urandom_range(0, 2))
        0: return OP_ADD_HEAD;
        1: return OP_ADD_TAIL;
        default: return OP_ADD_MID;
      endcase
    end
    case ($urandom_range(0, 2))
      0: return OP_REM_HEAD;
      1: return OP_REM_TAIL;
      default: return OP_REM_MID;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [2:0] code, input logic [31:0] val,
                           input logic typed, input out_word_t want);
    out_word_t predicted;
    start <= 1'b1;
    in_data <= in_word_t'({code, val});
    do @(posedge clk); while (busy);
    predicted = queue_op_result(code, val);
    due_words.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    if (due_words.size() != 0) begin
      start <= 1'b0;
      while (due_words.size() != 0) @(negedge clk);
    end
  endtask

  // stops after length words, 8 words after hitting target, or at RANDOM_ITEMS
  task automatic run_phase(input int add_pct, input int target, input int length);
    int extra;
    bit calm;
    extra = -1;
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < length && extra != 0 && sent < RANDOM_ITEMS; i++) begin
      send_word(pick_op(add_pct), pick_value(), 1'b0, '0);
      sent++;
      if (!calm) idle(pick_gap());
      if (extra > 0) extra--;
      else if (extra < 0 && slots.size() == target) extra = 8;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (out_valid) begin
      if (due_words.size() == 0) begin
        $error("result word with nothing expected: value_out %0d status %0d count %0d",
               out_data.value_out, out_data.status, out_data.count);
        mismatches++;
      end else begin
        want = due_words.pop_front();
        if (out_data.value_out !== want.value_out) begin
          $error("value_out expected %0d got %0d", want.value_out, out_data.value_out);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.count !== want.count) begin
          $error("count expected %0d got %0d", want.count, out_data.count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("triple_ended_queue verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int round;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i].code, DIRECTED[i].val, DIRECTED[i].typed, DIRECTED[i].want);
      idle(pick_gap());
    end
    drain_results();

    round = 0;
    while (sent < RANDOM_ITEMS) begin
      case (round % 3)
        0: run_phase(85, DEPTH, 2000);
        1: run_phase(15, 0, 2000);
        default: run_phase(50, -1, 150);
      endcase
      if ($urandom_range(0, 1) != 0 || round == 0) drain_results();
      round++;
    end

    drain_results();
    repeat (2 * LATENCY) @(negedge clk);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("triple_ended_queue verification clean");
    end else begin
      $display("triple_ended_queue verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
